>>> hw/rtl/snapid_pkg.sv
// Shared constants, types and helpers of the single-neuron adaptive PID block.
package snapid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_W      = 31;
    localparam int MUL_W      = 40;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIVD_W     = DATA_WIDTH + FRAC_BITS;
    localparam int DIVS_W     = DATA_WIDTH + 2;
    localparam int TERM_W     = DATA_WIDTH + 3;
    localparam int NORM_W     = FRAC_BITS + 1;
    localparam int DOT_W      = 54;
    localparam int CNT_W      = 6;

    localparam logic [MUL_W-1:0] CAP_MAG = {MUL_W{1'b1}};

    localparam logic [2:0] REG_GAIN_K      = 3'd0;
    localparam logic [2:0] REG_RATE_P      = 3'd1;
    localparam logic [2:0] REG_RATE_I      = 3'd2;
    localparam logic [2:0] REG_RATE_D      = 3'd3;
    localparam logic [2:0] REG_OUT_MIN     = 3'd4;
    localparam logic [2:0] REG_OUT_MAX     = 3'd5;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd6;
    localparam logic [2:0] REG_WEIGHT_INIT = 3'd7;

    localparam logic [CFG_W-1:0]      GAIN_K_RST      = 31'd7864;
    localparam logic [CFG_W-1:0]      RATE_P_RST      = 31'd26214;
    localparam logic [CFG_W-1:0]      RATE_I_RST      = 31'd22938;
    localparam logic [CFG_W-1:0]      RATE_D_RST      = 31'd26214;
    localparam logic [DATA_WIDTH-1:0] OUT_MIN_RST     = 32'd0;
    localparam logic [DATA_WIDTH-1:0] OUT_MAX_RST     = 32'd6553600;
    localparam logic [CFG_W-1:0]      DEAD_BAND_RST   = 31'd3277;
    localparam logic [DATA_WIDTH-1:0] WEIGHT_INIT_RST = 32'd6554;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // (a*b) >> FRAC_BITS, saturated at CAP_MAG
    function automatic logic [MUL_W-1:0] sat_cap(input logic [PROD_W-1:0] p);
        logic [PROD_W-FRAC_BITS-1:0] sh;
        sh = p[PROD_W-1:FRAC_BITS];
        if (|sh[PROD_W-FRAC_BITS-1:MUL_W]) begin
            sat_cap = CAP_MAG;
        end else begin
            sat_cap = sh[MUL_W-1:0];
        end
    endfunction

    function automatic logic [DATA_WIDTH-1:0] mag32(input logic [DATA_WIDTH-1:0] v);
        mag32 = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

>>> hw/rtl/snapid_mul.sv
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
module snapid_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [snapid_pkg::MUL_W-1:0]    a,
    input  logic [snapid_pkg::MUL_W-1:0]    b,
    output logic [snapid_pkg::PROD_W-1:0]   prod,
    output snapid_pkg::unit_stat_t          stat
);

    localparam int W = snapid_pkg::MUL_W;

    logic [W-1:0]                     mcand_reg;
    logic [snapid_pkg::PROD_W-1:0]    p_reg, p_next;
    logic [snapid_pkg::CNT_W-1:0]     cnt_reg;
    logic                             busy_reg, done_reg;
    logic [W:0]                       sum;

    always_comb begin
        sum    = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, mcand_reg} : {(W+1){1'b0}});
        p_next = {sum, p_reg[W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                mcand_reg <= a;
                p_reg     <= {{W{1'b0}}, b};
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                p_reg   <= p_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == snapid_pkg::CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod      = p_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/snapid_div.sv
// Restoring divider, one quotient bit per cycle.
module snapid_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [snapid_pkg::DIVD_W-1:0]   dividend,
    input  logic [snapid_pkg::DIVS_W-1:0]   divisor,
    output logic [snapid_pkg::DIVD_W-1:0]   quo,
    output snapid_pkg::unit_stat_t          stat
);

    localparam int QW = snapid_pkg::DIVD_W;
    localparam int DW = snapid_pkg::DIVS_W;

    logic [DW-1:0]                 rem_reg, d_reg;
    logic [QW-1:0]                 q_reg;
    logic [snapid_pkg::CNT_W-1:0]  cnt_reg;
    logic                          busy_reg, done_reg;
    logic [DW:0]                   rem_sh;
    logic [DW+1:0]                 diff;
    logic                          fits;

    always_comb begin
        rem_sh = {rem_reg, q_reg[QW-1]};
        diff   = {1'b0, rem_sh} - {2'b0, d_reg};
        fits   = !diff[DW+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                rem_reg  <= '0;
                q_reg    <= dividend;
                d_reg    <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // partial remainder stays below the divisor, so DW bits hold it
                rem_reg <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
                q_reg   <= {q_reg[QW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == snapid_pkg::CNT_W'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/single_neuron_adaptive_pid.sv
// Top level: single-neuron adaptive PID controller with bit-serial datapath.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = setpoint, measured
//  m_        out  m_tvalid/m_tready  m_tdata = drive, m_tuser = weight_fault
//  cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// Inside the dead band or with a zero weight sum an item skips the divider and the
// dot and gain products and runs only the learning products; otherwise its time is
// set by the serial divider (once per weight) and the shared serial multiplier
// (13 products in all, learning included). Reset is synchronous and loads
// the register defaults. A stalled result holds in the output register while the
// next transfer is taken; the commit of that next item waits for the slot to free.
module single_neuron_adaptive_pid (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] setpoint, [63:32] measured
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] drive
    output logic        m_tuser,    // [0] weight_fault
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int DW  = snapid_pkg::DATA_WIDTH;
    localparam int FB  = snapid_pkg::FRAC_BITS;
    localparam int MW  = snapid_pkg::MUL_W;
    localparam int TW  = snapid_pkg::TERM_W;
    localparam int NW  = snapid_pkg::NORM_W;
    localparam int OW  = snapid_pkg::DOT_W;
    localparam int SW  = snapid_pkg::DIVS_W;
    localparam int CW  = snapid_pkg::CFG_W;
    localparam int AW  = MW + 3;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_START, S_DIV_WAIT, S_DOT_START, S_DOT_WAIT,
        S_GAIN_START, S_GAIN_WAIT, S_APPLY, S_LEARN_START, S_LEARN_WAIT, S_COMMIT
    } state_t;

    state_t state_reg;

    logic [CW-1:0]        gain_k_reg, dead_band_reg;
    logic [CW-1:0]        rate_reg [3];      // i, p, d
    logic signed [DW-1:0] out_min_reg, out_max_reg, weight_init_reg;
    logic signed [DW-1:0] err_last_reg, err_prev_reg, out_reg;
    logic signed [DW-1:0] w_reg  [3];        // i, p, d
    logic signed [DW-1:0] wn_reg [3];
    logic signed [TW-1:0] x_reg  [3];        // x0, x1, x2
    logic signed [NW:0]   norm_reg [3];
    logic signed [DW-1:0] e_reg, result_reg;
    logic [SW-1:0]        sabs_reg;
    logic signed [OW-1:0] dot_reg;
    logic signed [MW:0]   delta_reg;
    logic [MW-1:0]        lm_reg;
    logic                 fault_reg;
    logic [1:0]           idx_reg, stg_reg;
    logic                 m_valid_reg, m_fault_reg;
    logic [DW-1:0]        m_data_reg;

    // accept-side terms
    logic signed [DW-1:0] sp, ms, e_sat;
    logic signed [DW:0]   d33;
    logic signed [TW-1:0] e35, el35, ep35;
    logic [DW-1:0]        abs_e;
    logic                 outside;
    logic [SW-1:0]        sabs;

    // serial units
    logic                         mul_start, div_start;
    logic [MW-1:0]                mul_a, mul_b;
    logic [snapid_pkg::PROD_W-1:0] prod;
    logic [snapid_pkg::DIVD_W-1:0] quo;
    snapid_pkg::unit_stat_t       mul_stat, div_stat;

    logic [DW-1:0]        w_mag;
    logic [TW-1:0]        x_mag;
    logic [NW-1:0]        norm_mag;
    logic [OW-1:0]        dot_mag;
    logic [MW-1:0]        capped;
    logic signed [OW-1:0] term_prod;
    logic signed [AW-1:0] apply_sum, clamp_hi;
    logic signed [DW-1:0] clamp_res;
    logic                 learn_neg;
    logic signed [AW-1:0] learn_sum;
    logic signed [DW-1:0] learn_w;

    always_comb begin
        sp    = s_tdata[31:0];
        ms    = s_tdata[63:32];
        d33   = {sp[DW-1], sp} - {ms[DW-1], ms};
        if (d33[DW] != d33[DW-1]) begin
            e_sat = d33[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            e_sat = d33[DW-1:0];
        end
        e35     = TW'(e_sat);
        el35    = TW'(err_last_reg);
        ep35    = TW'(err_prev_reg);
        abs_e   = snapid_pkg::mag32(e_sat);
        outside = abs_e > {1'b0, dead_band_reg};
        sabs    = SW'(snapid_pkg::mag32(w_reg[0])) + SW'(snapid_pkg::mag32(w_reg[1]))
                + SW'(snapid_pkg::mag32(w_reg[2]));
    end

    always_comb begin
        w_mag     = snapid_pkg::mag32(w_reg[idx_reg]);
        x_mag     = x_reg[idx_reg][TW-1] ? TW'(-x_reg[idx_reg]) : x_reg[idx_reg];
        norm_mag  = norm_reg[idx_reg][NW] ? NW'(-norm_reg[idx_reg]) : norm_reg[idx_reg][NW-1:0];
        dot_mag   = dot_reg[OW-1] ? OW'(-dot_reg) : dot_reg;
        capped    = snapid_pkg::sat_cap(prod);
        term_prod = (norm_reg[idx_reg][NW] ^ x_reg[idx_reg][TW-1])
                  ? -OW'(prod[OW-1:0]) : OW'(prod[OW-1:0]);

        apply_sum = AW'(out_reg) + AW'(delta_reg);
        clamp_hi  = (apply_sum > AW'(out_max_reg)) ? AW'(out_max_reg) : apply_sum;
        clamp_res = (clamp_hi < AW'(out_min_reg)) ? out_min_reg : clamp_hi[DW-1:0];

        learn_neg = e_reg[DW-1] ^ result_reg[DW-1] ^ x_reg[idx_reg][TW-1];
        learn_sum = AW'(w_reg[idx_reg])
                  + (learn_neg ? -AW'({1'b0, capped}) : AW'({1'b0, capped}));
        if (learn_sum > $signed(AW'({1'b0, {(DW-1){1'b1}}}))) begin
            learn_w = {1'b0, {(DW-1){1'b1}}};
        end else if (learn_sum < -$signed(AW'({1'b1, {(DW-1){1'b0}}}))) begin
            learn_w = {1'b1, {(DW-1){1'b0}}};
        end else begin
            learn_w = learn_sum[DW-1:0];
        end
    end

    always_comb begin
        div_start = (state_reg == S_DIV_START);
        mul_start = (state_reg == S_DOT_START) || (state_reg == S_GAIN_START)
                 || (state_reg == S_LEARN_START);
        mul_a = MW'(norm_mag);
        mul_b = MW'(x_mag);
        case (state_reg)
            S_GAIN_START: begin
                mul_a = MW'(dot_mag >> FB);
                mul_b = MW'(gain_k_reg);
            end
            S_LEARN_START: begin
                case (stg_reg)
                    2'd0: begin
                        mul_a = MW'(rate_reg[idx_reg]);
                        mul_b = MW'(snapid_pkg::mag32(e_reg));
                    end
                    2'd1: begin
                        mul_a = lm_reg;
                        mul_b = MW'(snapid_pkg::mag32(result_reg));
                    end
                    default: begin
                        mul_a = lm_reg;
                        mul_b = MW'(x_mag);
                    end
                endcase
            end
            default: ;
        endcase
    end

    snapid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (prod),
        .stat    (mul_stat)
    );

    snapid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({w_mag, {FB{1'b0}}}),
        .divisor  (sabs_reg),
        .quo      (quo),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            idx_reg         <= '0;
            stg_reg         <= '0;
            gain_k_reg      <= snapid_pkg::GAIN_K_RST;
            rate_reg[0]     <= snapid_pkg::RATE_I_RST;
            rate_reg[1]     <= snapid_pkg::RATE_P_RST;
            rate_reg[2]     <= snapid_pkg::RATE_D_RST;
            out_min_reg     <= snapid_pkg::OUT_MIN_RST;
            out_max_reg     <= snapid_pkg::OUT_MAX_RST;
            dead_band_reg   <= snapid_pkg::DEAD_BAND_RST;
            weight_init_reg <= snapid_pkg::WEIGHT_INIT_RST;
            err_last_reg    <= '0;
            err_prev_reg    <= '0;
            out_reg         <= snapid_pkg::OUT_MIN_RST;
            for (int k = 0; k < 3; k++) begin
                w_reg[k] <= snapid_pkg::WEIGHT_INIT_RST;
            end
        end else begin
            // the commit state reloads the slot itself when it frees
            if (m_valid_reg && m_tready && (state_reg != S_COMMIT)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    snapid_pkg::REG_GAIN_K:    gain_k_reg    <= cfg_wdata[CW-1:0];
                    snapid_pkg::REG_RATE_P:    rate_reg[1]   <= cfg_wdata[CW-1:0];
                    snapid_pkg::REG_RATE_I:    rate_reg[0]   <= cfg_wdata[CW-1:0];
                    snapid_pkg::REG_RATE_D:    rate_reg[2]   <= cfg_wdata[CW-1:0];
                    snapid_pkg::REG_OUT_MIN: begin
                        out_min_reg <= cfg_wdata;
                        out_reg     <= cfg_wdata;
                    end
                    snapid_pkg::REG_OUT_MAX:   out_max_reg   <= cfg_wdata;
                    snapid_pkg::REG_DEAD_BAND: dead_band_reg <= cfg_wdata[CW-1:0];
                    snapid_pkg::REG_WEIGHT_INIT: begin
                        weight_init_reg <= cfg_wdata;
                        for (int k = 0; k < 3; k++) begin
                            w_reg[k] <= cfg_wdata;
                        end
                    end
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        e_reg     <= e_sat;
                        x_reg[0]  <= e35;
                        x_reg[1]  <= e35 - el35;
                        x_reg[2]  <= e35 - (el35 <<< 1) + ep35;
                        sabs_reg  <= sabs;
                        dot_reg   <= '0;
                        delta_reg <= '0;
                        idx_reg   <= '0;
                        fault_reg <= outside && (sabs == '0);
                        state_reg <= (outside && (sabs != '0)) ? S_DIV_START : S_APPLY;
                    end
                end
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_stat.done) begin
                        norm_reg[idx_reg] <= w_reg[idx_reg][DW-1] ? -(NW+1)'(quo[NW-1:0])
                                                                  : (NW+1)'(quo[NW-1:0]);
                        if (idx_reg == 2'd2) begin
                            idx_reg   <= '0;
                            state_reg <= S_DOT_START;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_DOT_START: state_reg <= S_DOT_WAIT;
                S_DOT_WAIT: begin
                    if (mul_stat.done) begin
                        dot_reg <= dot_reg + term_prod;
                        if (idx_reg == 2'd2) begin
                            idx_reg   <= '0;
                            state_reg <= S_GAIN_START;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DOT_START;
                        end
                    end
                end
                S_GAIN_START: state_reg <= S_GAIN_WAIT;
                S_GAIN_WAIT: begin
                    if (mul_stat.done) begin
                        delta_reg <= dot_reg[OW-1] ? -(MW+1)'(capped) : (MW+1)'(capped);
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    result_reg <= clamp_res;
                    idx_reg    <= '0;
                    stg_reg    <= '0;
                    state_reg  <= S_LEARN_START;
                end
                S_LEARN_START: state_reg <= S_LEARN_WAIT;
                S_LEARN_WAIT: begin
                    if (mul_stat.done) begin
                        if (stg_reg == 2'd2) begin
                            wn_reg[idx_reg] <= learn_w;
                            stg_reg         <= '0;
                            if (idx_reg == 2'd2) begin
                                state_reg <= S_COMMIT;
                            end else begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= S_LEARN_START;
                            end
                        end else begin
                            lm_reg    <= capped;
                            stg_reg   <= stg_reg + 1'b1;
                            state_reg <= S_LEARN_START;
                        end
                    end
                end
                S_COMMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        for (int k = 0; k < 3; k++) begin
                            w_reg[k] <= wn_reg[k];
                        end
                        err_prev_reg <= err_last_reg;
                        err_last_reg <= e_reg;
                        out_reg      <= result_reg;
                        m_data_reg   <= result_reg;
                        m_fault_reg  <= fault_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_fault_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while an item is in work");

    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!mul_stat.busy && !div_stat.busy))
        else $error("serial unit busy while idle");

    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_commit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMMIT && m_valid_reg && !m_tready) |=> $stable(m_tdata))
        else $error("held result overwritten");

endmodule

>>> verif/snapid_checker.sv
// Checker for the adaptive PID block: predicts each drive/fault result and compares.
`timescale 1ns / 1ps
module snapid_checker
    import snapid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [31:0] drive;
        logic        fault;
    } ctrl_out_t;

    localparam bit [63:0] MAG_CAP = 64'(CAP_MAG);

    ctrl_out_t drive_q[$];

    bit [63:0] gain, rp, ri, rd, band;
    longint    lo_clamp, hi_clamp, w_init;
    longint    err_1, err_2, out_acc, wp, wi, wd;

    function automatic bit [63:0] absval(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // fixed point magnitude product with the 40-bit cap; high part fits in 64 bits
    function automatic bit [63:0] qmul(bit [63:0] a, bit [63:0] b);
        bit [63:0] hi, r;
        if (a > MAG_CAP) a = MAG_CAP;
        if (b > MAG_CAP) b = MAG_CAP;
        hi = (a >> FRAC_BITS) * b;
        if (hi > MAG_CAP) return MAG_CAP;
        r = hi + (((a & 64'hFFFF) * b) >> FRAC_BITS);
        return r > MAG_CAP ? MAG_CAP : r;
    endfunction

    function automatic longint adapt(longint w, bit [63:0] rate, longint e, longint u,
                                     longint x);
        bit [63:0] m;
        bit        neg;
        m   = qmul(qmul(qmul(rate, absval(e)), absval(u)), absval(x));
        neg = (e < 0) ^ (u < 0) ^ (x < 0);
        return sat32(w + (neg ? -longint'(m) : longint'(m)));
    endfunction

    function automatic ctrl_out_t pid_step(logic [31:0] sp_bits, logic [31:0] ms_bits);
        ctrl_out_t r;
        longint    e, x1, x2, delta, s, ni, np, nd, dot, nxt;
        bit [63:0] sabs;
        e     = sat32(longint'($signed(sp_bits)) - longint'($signed(ms_bits)));
        x1    = e - err_1;
        x2    = e - 2 * err_1 + err_2;
        delta = 0;
        r.fault = 1'b0;
        if (absval(e) > band) begin
            sabs = absval(wi) + absval(wp) + absval(wd);
            if (sabs == 0) begin
                r.fault = 1'b1;
            end else begin
                s     = longint'(sabs);
                ni    = (wi * 65536) / s;
                np    = (wp * 65536) / s;
                nd    = (wd * 65536) / s;
                dot   = ni * e + np * x1 + nd * x2;
                delta = longint'(qmul(absval(dot) >> FRAC_BITS, gain));
                if (dot < 0) delta = -delta;
            end
        end
        nxt = out_acc + delta;
        if (nxt > hi_clamp) nxt = hi_clamp;
        if (nxt < lo_clamp) nxt = lo_clamp;
        out_acc = nxt;
        wi = adapt(wi, ri, e, nxt, e);
        wp = adapt(wp, rp, e, nxt, x1);
        wd = adapt(wd, rd, e, nxt, x2);
        err_2 = err_1;
        err_1 = e;
        r.drive = nxt[31:0];
        return r;
    endfunction

    assign pending = drive_q.size();

    always @(posedge aclk) begin
        ctrl_out_t exp_r;
        if (!aresetn) begin
            gain = 64'(GAIN_K_RST); rp = 64'(RATE_P_RST); ri = 64'(RATE_I_RST);
            rd = 64'(RATE_D_RST); band = 64'(DEAD_BAND_RST);
            lo_clamp = longint'($signed(OUT_MIN_RST));
            hi_clamp = longint'($signed(OUT_MAX_RST));
            w_init   = longint'($signed(WEIGHT_INIT_RST));
            err_1 = 0; err_2 = 0; out_acc = lo_clamp;
            wp = w_init; wi = w_init; wd = w_init;
            drive_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GAIN_K:    gain = 64'(cfg_wdata[30:0]);
                    REG_RATE_P:    rp = 64'(cfg_wdata[30:0]);
                    REG_RATE_I:    ri = 64'(cfg_wdata[30:0]);
                    REG_RATE_D:    rd = 64'(cfg_wdata[30:0]);
                    REG_OUT_MIN: begin
                        lo_clamp = longint'($signed(cfg_wdata));
                        out_acc  = lo_clamp;
                    end
                    REG_OUT_MAX:   hi_clamp = longint'($signed(cfg_wdata));
                    REG_DEAD_BAND: band = 64'(cfg_wdata[30:0]);
                    REG_WEIGHT_INIT: begin
                        w_init = longint'($signed(cfg_wdata));
                        wp = w_init; wi = w_init; wd = w_init;
                    end
                    default: ;
                endcase
            end
            // compare before predicting: a result never belongs to the item of the same edge
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result drive=%h fault=%b", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = drive_q.pop_front();
                    if (exp_r.drive !== m_tdata || exp_r.fault !== m_tuser) begin
                        if (fail_count < 10)
                            $display("mismatch: drive exp %h got %h, fault exp %b got %b",
                                     exp_r.drive, m_tdata, exp_r.fault, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(pid_step(s_tdata[31:0], s_tdata[63:32]));
        end
    end

endmodule

>>> verif/tb.sv
// Testbench top: clock, reset, stimulus and configuration phases, verdict.
`timescale 1ns / 1ps
module tb;
    import snapid_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // [31:0] setpoint, [63:32] measured
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] drive
    logic        m_tuser;     // [0] weight_fault
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int fail_count;
    int pending;
    int idle_cycles;
    bit src_steady;
    bit snk_steady;

    localparam int WATCHDOG = 6000;

    single_neuron_adaptive_pid u_top (.*);

    snapid_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run is ended if nothing transfers for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result sink with random backpressure per transfer
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = snk_steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_sample(logic [31:0] sp, logic [31:0] ms);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ms, sp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic reg_done();
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h1_0000);
            3: return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h8000);
        endcase
    endfunction

    task automatic random_setup();
        logic [31:0] a, b;
        case ($urandom_range(0, 4))
            0: begin a = 32'h8000_0000; b = 32'h7FFF_FFFF; end
            1: begin a = $urandom; b = $urandom; end  // may be inverted
            default: begin
                a = -$urandom_range(0, 32'h0100_0000);
                b = $urandom_range(0, 32'h0100_0000);
            end
        endcase
        reg_write(REG_GAIN_K, pick_rate());
        reg_write(REG_RATE_P, pick_rate());
        reg_write(REG_RATE_I, pick_rate());
        reg_write(REG_RATE_D, pick_rate());
        reg_write(REG_OUT_MAX, b);
        reg_write(REG_OUT_MIN, a);
        case ($urandom_range(0, 5))
            0: reg_write(REG_DEAD_BAND, 32'd0);
            1: reg_write(REG_DEAD_BAND, 32'h7FFF_FFFF);
            default: reg_write(REG_DEAD_BAND, $urandom_range(0, 32'h2_0000));
        endcase
        case ($urandom_range(0, 6))
            0: reg_write(REG_WEIGHT_INIT, 32'd0);
            1: reg_write(REG_WEIGHT_INIT, 32'h8000_0000);
            2: reg_write(REG_WEIGHT_INIT, 32'h7FFF_FFFF);
            3: reg_write(REG_WEIGHT_INIT, $urandom);
            default: reg_write(REG_WEIGHT_INIT, $urandom_range(0, 32'h2_0000) - 32'h1_0000);
        endcase
        reg_done();
    endtask

    initial begin
        logic [31:0] sp, err;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_GAIN_K;
        cfg_wdata  = '0;
        src_steady = 1'b0;
        snk_steady = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: zero error, dead band edges, extremes of both fields
        send_sample(32'd0, 32'd0);
        send_sample(32'd3277, 32'd0);
        send_sample(32'd3278, 32'd0);
        send_sample(32'd0, 32'd3278);
        send_sample(32'h0010_0000, 32'd0);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0020_0000, 32'hFFF0_0000);
        drain();

        // zero weight sum: output holds, fault outside the dead band only
        reg_write(REG_WEIGHT_INIT, 32'd0);
        reg_done();
        send_sample(32'h0001_0000, 32'd0);
        send_sample(32'd100, 32'd0);
        send_sample(32'h0005_0000, 32'd0);
        drain();

        // inverted clamp limits, extreme gain and rates, zero dead band
        reg_write(REG_GAIN_K, 32'h7FFF_FFFF);
        reg_write(REG_RATE_P, 32'h7FFF_FFFF);
        reg_write(REG_RATE_I, 32'd0);
        reg_write(REG_RATE_D, 32'h7FFF_FFFF);
        reg_write(REG_OUT_MAX, 32'hFFFF_0000);
        reg_write(REG_OUT_MIN, 32'h0001_0000);
        reg_write(REG_DEAD_BAND, 32'd0);
        reg_write(REG_WEIGHT_INIT, 32'h8000_0000);
        reg_done();
        send_sample(32'h0003_0000, 32'd0);
        send_sample(32'hFFFD_0000, 32'd0);
        send_sample(32'd1, 32'd0);
        drain();

        reg_write(REG_OUT_MAX, 32'h7FFF_FFFF);
        reg_write(REG_OUT_MIN, 32'h8000_0000);
        reg_write(REG_WEIGHT_INIT, 32'h7FFF_FFFF);
        reg_write(REG_DEAD_BAND, 32'h7FFF_FFFF);
        reg_done();
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h1234_5678, 32'h0000_0000);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_setup();
            for (int n = 0; n < 200; n++) begin
                if (n % 50 == 0) begin
                    src_steady = ($urandom_range(0, 3) == 0);
                    snk_steady = ($urandom_range(0, 3) == 0);
                end
                sp = $urandom;
                case ($urandom_range(0, 7))
                    0: err = $urandom_range(0, 8000) - 4000;
                    1: err = $urandom;
                    2: err = sp ^ $urandom;
                    default: err = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                endcase
                send_sample(sp, sp - err);
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
